@@ rtl/core/binned_free_list_allocator_top_macros.svh @@
// assertion macros for the binned free list allocator
`ifndef BINNED_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define BINNED_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BFLA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFLA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bfla_pkg.sv @@
// shared types and constants of the binned free list allocator
`timescale 1ns / 1ps
`default_nettype none
package bfla_pkg;
   localparam int CLS_W = 5;
   localparam int ADDR_W = 20;
   localparam int SIZE_W = 32;
   localparam int VAL_W = SIZE_W - 3;
   localparam int RESET_CLASS = 7;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NULL = 2'd1;
   localparam logic [1:0] ST_EXHAUSTED = 2'd2;
   localparam logic [1:0] ST_TOO_LARGE = 2'd3;

   typedef struct packed {
      logic [CLS_W-1:0] cls;
      logic has_next;
   } hdr_meta_type;

   typedef struct packed {
      logic en;
      logic valid;
      logic [CLS_W-1:0] cls;
   } lh_wr_type;
endpackage
`default_nettype wire

@@ rtl/core/bfla_hdr_mem.sv @@
// block header memory, one entry per granule, registered read
`timescale 1ns / 1ps
`default_nettype none
module bfla_hdr_mem import bfla_pkg::*; #(
   parameter int GRANULES = 131072,
   parameter int GW = 17
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic rd_en,
   input wire logic [GW-1:0] rd_addr,
   output hdr_meta_type rd_meta,
   output logic [GW-1:0] rd_next,
   input wire logic wr_en,
   input wire logic [GW-1:0] wr_addr,
   input wire hdr_meta_type wr_meta,
   input wire logic [GW-1:0] wr_next
);
   localparam int MW = $bits(hdr_meta_type) + GW;

   logic [MW-1:0] hdr_mem [GRANULES];
   logic [MW-1:0] rd_data_ff;
   logic g0_written_ff;
   logic g0_written_in;
   logic rd_g0_ff;

   assign g0_written_in = g0_written_ff | (wr_en && (wr_addr == '0));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[wr_addr] <= {wr_meta, wr_next};
      end
      if (rd_en) begin
         rd_data_ff <= hdr_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g0_written_ff <= 1'b0;
         rd_g0_ff <= 1'b0;
      end else begin
         g0_written_ff <= g0_written_in;
         if (rd_en) begin
            rd_g0_ff <= (rd_addr == '0) && !g0_written_ff;
         end
      end
   end

   // granule 0 holds the initial block until first written
   always_comb begin
      if (rd_g0_ff) begin
         rd_meta.cls = CLS_W'(RESET_CLASS);
         rd_meta.has_next = 1'b0;
         rd_next = '0;
      end else begin
         rd_meta = rd_data_ff[MW-1:GW];
         rd_next = rd_data_ff[GW-1:0];
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/bfla_heads.sv @@
// free list heads, one valid bit and head granule per size class
`timescale 1ns / 1ps
`default_nettype none
module bfla_heads import bfla_pkg::*; #(
   parameter int NUM_CLASSES = 23,
   parameter int GW = 17
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic [CLS_W-1:0] sel,
   output logic sel_valid,
   output logic [GW-1:0] sel_head,
   input wire lh_wr_type wr,
   input wire logic [GW-1:0] wr_gran
);
   localparam int LW = $clog2(NUM_CLASSES);

   logic [NUM_CLASSES-1:0] valid_ff;
   logic [GW-1:0] head_ff [NUM_CLASSES];

   assign sel_valid = valid_ff[sel[LW-1:0]];
   assign sel_head = head_ff[sel[LW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= {{(NUM_CLASSES-1){1'b0}}, 1'b1} << RESET_CLASS;
         head_ff[RESET_CLASS] <= '0;
      end else if (wr.en) begin
         valid_ff[wr.cls[LW-1:0]] <= wr.valid;
         head_ff[wr.cls[LW-1:0]] <= wr_gran;
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/binned_free_list_allocator_top.sv @@
// top level of the binned free list allocator
`timescale 1ns / 1ps
`default_nettype none
`include "binned_free_list_allocator_top_macros.svh"
// Heap allocator with one LIFO free list per power-of-two size class.
// A request is taken when start is high and busy is low: req_cmd selects
// allocate (req_size bytes) or free (req_data_addr). Exactly one response
// follows, shown for one cycle on rsp_valid with rsp_result_addr and
// rsp_status; the receiver cannot stall it, and busy stays high until the
// response cycle, so one request is in flight at a time.
// Steps: a zero size or an ignored free is answered at once; a free reads
// the block header and pushes the block on its list. An allocate finds
// its class by halving the size class by class, and a size still left at
// the top class is too large; a hit pops its list. On a miss each larger
// class is looked at in turn; a larger block found is popped, split into
// smaller pieces and the list checked again, else the heap break is bumped.
// The header memory's single read and write port sets the per-step work.
// After reset one class-7 block at offset 0 sits on list 7 and the heap
// break is at the end of it; the header memory needs no clearing pass.
module binned_free_list_allocator_top import bfla_pkg::*; #(
   parameter longint unsigned HEAP_BYTES = 1048576,
   parameter int NUM_CLASSES = 23,
   parameter int HEADER_BYTES = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic req_cmd,
   input wire logic [SIZE_W-1:0] req_size,
   input wire logic [ADDR_W-1:0] req_data_addr,
   output logic rsp_valid,
   output logic [ADDR_W-1:0] rsp_result_addr,
   output logic [1:0] rsp_status
);
   localparam longint unsigned GRANULES = HEAP_BYTES / 8;
   localparam int GW = $clog2(GRANULES);
   localparam int HW = $clog2(HEAP_BYTES) + 2;
   localparam int CW = NUM_CLASSES + 5;
   localparam int BW = ((HW > CW) ? HW : CW) + 1;
   localparam logic [BW-1:0] HEAP_LIM = BW'(HEAP_BYTES);
   localparam logic [BW-1:0] HDR = BW'(HEADER_BYTES);
   localparam logic [BW-1:0] RESET_BRK = BW'((8 << RESET_CLASS) + HEADER_BYTES);

   typedef enum logic [3:0] {
      S_IDLE, S_CLASS, S_CHECK, S_SEARCH, S_SPLIT_RD, S_SPLIT, S_POP_RD, S_BUMP, S_FREE_RD
   } state_type;

   state_type state_ff, state_in;
   logic [CLS_W-1:0] cls_ff, cls_in, k_ff, k_in, j_ff, j_in;
   logic [VAL_W-1:0] v_ff, v_in;
   logic [BW-1:0] cbytes_ff, cbytes_in, kbytes_ff, kbytes_in, jbytes_ff, jbytes_in;
   logic [BW-1:0] pos_ff, pos_in, limit_ff, limit_in, brk_ff, brk_in;
   logic [GW-1:0] g_ff, g_in;
   logic split_done_ff, split_done_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic [CLS_W-1:0] lh_sel;
   logic lh_valid;
   logic [GW-1:0] lh_head;
   lh_wr_type lh_wr;
   logic [GW-1:0] lh_wr_gran;

   logic mrd_en, mwr_en;
   logic [GW-1:0] mrd_addr, mwr_addr, mrd_next, mwr_next;
   hdr_meta_type mrd_meta, mwr_meta;

   logic [ADDR_W-1:0] fb;
   logic [BW-1:0] fb_ext, jb, end_pos, need, gpos;

   bfla_heads #(.NUM_CLASSES(NUM_CLASSES), .GW(GW)) u_heads (
      .clock(clock), .reset(reset), .sel(lh_sel), .sel_valid(lh_valid),
      .sel_head(lh_head), .wr(lh_wr), .wr_gran(lh_wr_gran)
   );

   bfla_hdr_mem #(.GRANULES(int'(GRANULES)), .GW(GW)) u_hdr_mem (
      .clock(clock), .reset(reset), .rd_en(mrd_en), .rd_addr(mrd_addr),
      .rd_meta(mrd_meta), .rd_next(mrd_next), .wr_en(mwr_en), .wr_addr(mwr_addr),
      .wr_meta(mwr_meta), .wr_next(mwr_next)
   );

   assign fb = req_data_addr - ADDR_W'(HEADER_BYTES);
   assign fb_ext = BW'(fb);
   assign jb = jbytes_ff >> 1;
   assign end_pos = pos_ff + jb + HDR;
   assign need = cbytes_ff + HDR;
   assign gpos = BW'({g_ff, 3'b000});

   always_comb begin
      state_in = state_ff;
      cls_in = cls_ff;
      k_in = k_ff;
      j_in = j_ff;
      v_in = v_ff;
      cbytes_in = cbytes_ff;
      kbytes_in = kbytes_ff;
      jbytes_in = jbytes_ff;
      pos_in = pos_ff;
      limit_in = limit_ff;
      brk_in = brk_ff;
      g_in = g_ff;
      split_done_in = split_done_ff;
      rsp_valid_in = 1'b0;
      rsp_addr_in = '0;
      rsp_status_in = ST_OK;
      lh_sel = cls_ff;
      lh_wr = '0;
      lh_wr_gran = '0;
      mrd_en = 1'b0;
      mrd_addr = lh_head;
      mwr_en = 1'b0;
      mwr_addr = g_ff;
      mwr_meta.cls = cls_ff;
      mwr_meta.has_next = 1'b0;
      mwr_next = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_FREE) begin
                  if (req_data_addr >= ADDR_W'(HEADER_BYTES) && fb[2:0] == 3'b000 &&
                      fb_ext < brk_ff) begin
                     mrd_en = 1'b1;
                     mrd_addr = fb_ext[GW+2:3];
                     g_in = fb_ext[GW+2:3];
                     state_in = S_FREE_RD;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end else if (req_size == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = ST_NULL;
               end else begin
                  v_in = VAL_W'((req_size - 1'b1) >> 3);
                  cls_in = '0;
                  cbytes_in = BW'(8);
                  split_done_in = 1'b0;
                  state_in = S_CLASS;
               end
            end
         end
         S_CLASS: begin
            if (v_ff == '0) begin
               state_in = S_CHECK;
            end else if (cls_ff == CLS_W'(NUM_CLASSES - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_TOO_LARGE;
               state_in = S_IDLE;
            end else begin
               cls_in = cls_ff + 1'b1;
               v_in = v_ff >> 1;
               cbytes_in = cbytes_ff << 1;
            end
         end
         S_CHECK: begin
            if (lh_valid) begin
               mrd_en = 1'b1;
               g_in = lh_head;
               state_in = S_POP_RD;
            end else if (split_done_ff) begin
               state_in = S_BUMP;
            end else begin
               k_in = cls_ff + 1'b1;
               kbytes_in = cbytes_ff << 1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            lh_sel = k_ff;
            if (k_ff == CLS_W'(NUM_CLASSES)) begin
               state_in = S_BUMP;
            end else if (lh_valid) begin
               mrd_en = 1'b1;
               g_in = lh_head;
               state_in = S_SPLIT_RD;
            end else begin
               k_in = k_ff + 1'b1;
               kbytes_in = kbytes_ff << 1;
            end
         end
         S_SPLIT_RD: begin
            lh_wr.en = 1'b1;
            lh_wr.cls = k_ff;
            lh_wr.valid = mrd_meta.has_next;
            lh_wr_gran = mrd_next;
            pos_in = gpos;
            limit_in = gpos + kbytes_ff + HDR;
            j_in = k_ff;
            jbytes_in = kbytes_ff;
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            lh_sel = j_ff - 1'b1;
            if (j_ff == '0 || end_pos > limit_ff) begin
               split_done_in = 1'b1;
               state_in = S_CHECK;
            end else begin
               mwr_en = 1'b1;
               mwr_addr = pos_ff[GW+2:3];
               mwr_meta.cls = j_ff - 1'b1;
               mwr_meta.has_next = lh_valid;
               mwr_next = lh_head;
               lh_wr.en = 1'b1;
               lh_wr.cls = j_ff - 1'b1;
               lh_wr.valid = 1'b1;
               lh_wr_gran = pos_ff[GW+2:3];
               pos_in = end_pos;
               j_in = j_ff - 1'b1;
               jbytes_in = jb;
            end
         end
         S_POP_RD: begin
            lh_wr.en = 1'b1;
            lh_wr.cls = cls_ff;
            lh_wr.valid = mrd_meta.has_next;
            lh_wr_gran = mrd_next;
            mwr_en = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_addr_in = ADDR_W'(gpos + HDR);
            state_in = S_IDLE;
         end
         S_BUMP: begin
            rsp_valid_in = 1'b1;
            if (brk_ff + need > HEAP_LIM) begin
               rsp_status_in = ST_EXHAUSTED;
            end else begin
               mwr_en = 1'b1;
               mwr_addr = brk_ff[GW+2:3];
               rsp_addr_in = ADDR_W'(brk_ff + HDR);
               brk_in = brk_ff + need;
            end
            state_in = S_IDLE;
         end
         S_FREE_RD: begin
            lh_sel = mrd_meta.cls;
            if (mrd_meta.cls < CLS_W'(NUM_CLASSES)) begin
               mwr_en = 1'b1;
               mwr_meta.cls = mrd_meta.cls;
               mwr_meta.has_next = lh_valid;
               mwr_next = lh_head;
               lh_wr.en = 1'b1;
               lh_wr.cls = mrd_meta.cls;
               lh_wr.valid = 1'b1;
               lh_wr_gran = g_ff;
            end
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         brk_ff <= RESET_BRK;
         split_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         brk_ff <= brk_in;
         split_done_ff <= split_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cls_ff <= cls_in;
      k_ff <= k_in;
      j_ff <= j_in;
      v_ff <= v_in;
      cbytes_ff <= cbytes_in;
      kbytes_ff <= kbytes_in;
      jbytes_ff <= jbytes_in;
      pos_ff <= pos_in;
      limit_ff <= limit_in;
      g_ff <= g_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_status = rsp_status_ff;

   `BFLA_ASSERT_NEXT(a_req_progress, clock, reset, start && !busy, busy || rsp_valid, "request dropped")
   `BFLA_ASSERT_NOW(a_fail_zero_addr, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_result_addr == '0, "failed request with nonzero address")
   `BFLA_ASSERT_NOW(a_break_bound, clock, reset, 1'b1, brk_ff <= HEAP_LIM, "heap break beyond heap")
   `BFLA_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "response while busy")
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench of the binned free list allocator
`timescale 1ns / 1ps
module tb import bfla_pkg::*;;

   localparam int NCLS = 23;
   localparam int NGRAN = 131072;
   localparam longint HEAP = 1048576;
   localparam int HDR = 16;
   localparam int LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = CMD_ALLOC;
   logic [SIZE_W-1:0] req_size = '0;
   logic [ADDR_W-1:0] req_data_addr = '0;
   logic rsp_valid;
   logic [ADDR_W-1:0] rsp_result_addr;
   logic [1:0] rsp_status;

   binned_free_list_allocator_top uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [1:0] status;
   } rsp_type;

   typedef struct {
      logic cmd;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] daddr;
      bit typed;
      logic [ADDR_W-1:0] exp_addr;
      logic [1:0] exp_status;
   } stim_type;

   // allocator state mirror
   bit bin_valid [NCLS];
   logic [17:0] bin_head [NCLS];
   logic [4:0] hdr_cls [NGRAN];
   bit hdr_link [NGRAN];
   logic [17:0] hdr_next [NGRAN];
   bit hdr_seen [NGRAN];
   longint brk;

   rsp_type pending [$];
   logic [ADDR_W-1:0] live_blocks [$];
   int errors = 0;
   int cycles = 0;

   function automatic int class_of(logic [31:0] size);
      logic [31:0] v;
      int bits;
      v = size - 32'd1;
      bits = 0;
      while (v != 0) begin
         bits++;
         v >>= 1;
      end
      return (bits <= 3) ? 0 : bits - 3;
   endfunction

   function automatic longint blk_bytes(int c);
      return (longint'(8) << c) + HDR;
   endfunction

   function automatic void put_hdr(int g, int c, bit lnk, logic [17:0] nxt);
      hdr_cls[g] = 5'(c);
      hdr_link[g] = lnk;
      hdr_next[g] = nxt;
      hdr_seen[g] = 1;
   endfunction

   function automatic void bin_push(int c, int g);
      put_hdr(g, c, bin_valid[c], bin_head[c]);
      bin_valid[c] = 1;
      bin_head[c] = 18'(g);
   endfunction

   function automatic int bin_pop(int c);
      int g;
      g = int'(bin_head[c]);
      bin_valid[c] = hdr_link[g];
      bin_head[c] = hdr_next[g];
      return g;
   endfunction

   function automatic void split_bin(int k);
      longint pos, lim;
      int j;
      pos = longint'(bin_pop(k)) * 8;
      lim = pos + blk_bytes(k);
      j = k;
      while (j > 0) begin
         j--;
         if (pos + blk_bytes(j) > lim) return;
         bin_push(j, int'(pos / 8));
         pos += blk_bytes(j);
      end
   endfunction

   function automatic rsp_type heap_step(logic cmd, logic [31:0] size, logic [19:0] daddr);
      rsp_type r;
      int c, k, g;
      longint b;
      r.addr = '0;
      r.status = ST_OK;
      if (cmd == CMD_ALLOC) begin
         if (size == 0) r.status = ST_NULL;
         else begin
            c = class_of(size);
            if (c >= NCLS) r.status = ST_TOO_LARGE;
            else begin
               if (!bin_valid[c])
                  for (k = c + 1; k < NCLS; k++)
                     if (bin_valid[k]) begin
                        split_bin(k);
                        break;
                     end
               if (bin_valid[c]) begin
                  g = bin_pop(c);
                  put_hdr(g, c, 0, '0);
                  r.addr = ADDR_W'(g * 8 + HDR);
               end else if (brk + blk_bytes(c) > HEAP) begin
                  r.status = ST_EXHAUSTED;
               end else begin
                  put_hdr(int'(brk / 8), c, 0, '0);
                  r.addr = ADDR_W'(brk + HDR);
                  brk += blk_bytes(c);
               end
            end
         end
      end else if (daddr >= HDR) begin
         b = longint'(daddr) - HDR;
         if (b[2:0] == 0 && b < brk && hdr_cls[b / 8] < NCLS)
            bin_push(int'(hdr_cls[b / 8]), int'(b / 8));
      end
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response addr %h status %0d",
               rsp_result_addr, rsp_status);
         end else begin
            e = pending.pop_front();
            if (e.addr !== rsp_result_addr || e.status !== rsp_status) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                     e.addr, e.status, rsp_result_addr, rsp_status);
            end
         end
      end
   end

   // drives one request and waits for it to be taken
   task automatic issue(stim_type s, bit idle_ok);
      rsp_type p;
      if (idle_ok && $urandom_range(99) < 8) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= s.cmd;
      req_size <= s.size;
      req_data_addr <= s.daddr;
      do @(posedge clock); while (busy !== 1'b0);
      p = heap_step(s.cmd, s.size, s.daddr);
      if (s.typed) begin
         p.addr = s.exp_addr;
         p.status = s.exp_status;
      end
      pending.push_back(p);
      if (s.cmd == CMD_ALLOC && p.status == ST_OK) live_blocks.push_back(p.addr);
   endtask

   function automatic stim_type row(logic cmd, logic [31:0] size, logic [19:0] daddr,
                                    bit typed = 0, logic [19:0] ea = 0, logic [1:0] es = ST_OK);
      stim_type s;
      s.cmd = cmd; s.size = size; s.daddr = daddr;
      s.typed = typed; s.exp_addr = ea; s.exp_status = es;
      return s;
   endfunction

   function automatic stim_type rand_item();
      stim_type s;
      int pick, idx;
      longint b;
      s = row(CMD_ALLOC, 0, ADDR_W'($urandom()));
      pick = $urandom_range(99);
      if (pick < 40) begin
         s.cmd = CMD_FREE;
         if (live_blocks.size() > 0 && $urandom_range(99) < 80) begin
            idx = $urandom_range(live_blocks.size() - 1);
            s.daddr = live_blocks[idx];
            live_blocks.delete(idx);
         end
         // never free a granule that never held a header
         b = longint'(s.daddr) - HDR;
         if (s.daddr >= HDR && b[2:0] == 0 && b < brk && !hdr_seen[b / 8])
            s.daddr[0] = 1'b1;
      end else begin
         pick = $urandom_range(99);
         if (pick < 55) s.size = $urandom_range(1, 64);
         else if (pick < 80) s.size = $urandom_range(1, 2048);
         else if (pick < 90) s.size = $urandom_range(1, 65536);
         else if (pick < 96) s.size = $urandom();
         else s.size = 0;
      end
      return s;
   endfunction

   initial begin
      stim_type dir [$];
      int n;
      foreach (bin_valid[i]) begin
         bin_valid[i] = 0;
         bin_head[i] = '0;
      end
      bin_valid[RESET_CLASS] = 1;
      put_hdr(0, RESET_CLASS, 0, '0);
      brk = blk_bytes(RESET_CLASS);

      dir.push_back(row(CMD_ALLOC, 1024, 20'hFFFFF, 1, 20'd16, ST_OK));
      dir.push_back(row(CMD_ALLOC, 0, 0, 1, 0, ST_NULL));
      dir.push_back(row(CMD_ALLOC, 32'hFFFFFFFF, 0, 1, 0, ST_TOO_LARGE));
      dir.push_back(row(CMD_ALLOC, 32'h02000001, 0, 1, 0, ST_TOO_LARGE));
      dir.push_back(row(CMD_ALLOC, 32'h02000000, 0, 1, 0, ST_EXHAUSTED));
      dir.push_back(row(CMD_ALLOC, 1, 0, 1, 20'd1056, ST_OK));
      dir.push_back(row(CMD_ALLOC, 8, 0));
      dir.push_back(row(CMD_FREE, 32'hFFFFFFFF, 20'd16, 1, 0, ST_OK));
      dir.push_back(row(CMD_ALLOC, 9, 0));
      dir.push_back(row(CMD_ALLOC, 16, 0));
      dir.push_back(row(CMD_ALLOC, 512, 0));
      dir.push_back(row(CMD_FREE, 0, 20'd0, 1, 0, ST_OK));
      dir.push_back(row(CMD_FREE, 0, 20'd15, 1, 0, ST_OK));
      dir.push_back(row(CMD_FREE, 0, 20'd17, 1, 0, ST_OK));
      dir.push_back(row(CMD_FREE, 0, 20'hFFFFF, 1, 0, ST_OK));
      dir.push_back(row(CMD_FREE, 0, 20'hFFFF0, 1, 0, ST_OK));
      dir.push_back(row(CMD_FREE, 0, 20'd1056, 1, 0, ST_OK));
      dir.push_back(row(CMD_FREE, 0, 20'd1056, 1, 0, ST_OK));
      dir.push_back(row(CMD_ALLOC, 3, 0));
      dir.push_back(row(CMD_ALLOC, 4, 0));
      dir.push_back(row(CMD_ALLOC, 5, 0));
      dir.push_back(row(CMD_ALLOC, 524288, 0));
      dir.push_back(row(CMD_ALLOC, 1048576, 0));
      dir.push_back(row(CMD_ALLOC, 4194304, 0, 1, 0, ST_EXHAUSTED));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir[i]) issue(dir[i], 1);
      for (n = 0; n < 700; n++) begin
         if (n == 350) begin
            start <= 1'b0;
            while (pending.size() != 0) @(posedge clock);
         end
         issue(rand_item(), n < 150 || n >= 400);
      end
      start <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
